FILE: hw/rtl/assert_macros.svh
// shared assertion macros, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/x86e_pkg.sv
package x86e_pkg;

	// longest encoding (prologue with imm32 frame size)
	localparam int MaxBytes = 11;
	localparam int LenW = 4;
	localparam int FifoDepth = 2;

	// instruction forms in request encoding order
	typedef enum logic [5:0] {
		CMD_MOV_RR, CMD_MOV_RI64, CMD_MOV_LOAD, CMD_MOV_STORE,
		CMD_ADD_RR, CMD_ADD_RI, CMD_SUB_RR, CMD_SUB_RI, CMD_IMUL_RR,
		CMD_CQO, CMD_IDIV, CMD_AND_RR, CMD_AND_RI8, CMD_OR_RR, CMD_XOR_RR,
		CMD_NOT, CMD_NEG, CMD_CMP_RR, CMD_CMP_RI, CMD_TEST_RR,
		CMD_SETE, CMD_SETNE, CMD_SETL, CMD_SETLE, CMD_SETG, CMD_SETGE,
		CMD_MOVZX, CMD_PUSH, CMD_POP, CMD_PUSH_IMM,
		CMD_JMP, CMD_JE, CMD_JNE, CMD_CALL, CMD_RET, CMD_LEAVE,
		CMD_PROLOGUE, CMD_EPILOGUE, CMD_SYSCALL
	} cmd_t;

	// stack registers with special encodings
	localparam logic [3:0] REG_RSP = 4'd4;
	localparam logic [3:0] REG_RBP = 4'd5;

	// one request transaction
	typedef struct packed {
		logic [5:0]         cmd;
		logic [3:0]         reg_a;
		logic [3:0]         reg_b;
		logic signed [63:0] imm_value;
	} req_t;

	// one result transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} res_t;

	// fully encoded instruction, bytes in memory order from index 0
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [LenW-1:0]          len;
	} frame_t;

endpackage

FILE: hw/rtl/x86e_front.sv
`include "assert_macros.svh"

module x86e_front import x86e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  req_t   req,
	input  logic   full,
	output logic   push,
	output frame_t frame
);

	localparam logic [31:0] JUMP_PLACEHOLDER = 32'hDEADBEEF;

	// field builders
	function automatic logic [7:0] rexb(logic w, logic [3:0] r, logic [3:0] b);
		return {4'h4, w, r[3], 1'b0, b[3]};
	endfunction

	function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
		return {md, rg, rm};
	endfunction

	// value lies in -128..127 as a signed 32-bit number
	function automatic logic fits8(logic [31:0] v);
		return (v[31:7] == '0) || (v[31:7] == '1);
	endfunction

	// append one byte
	function automatic frame_t put(frame_t f, logic [7:0] b);
		frame_t g;
		g = f;
		if (f.len < LenW'(MaxBytes)) begin
			g.bytes[f.len] = b;
			g.len = f.len + 1'b1;
		end
		return g;
	endfunction

	// append 32 bits little-endian
	function automatic frame_t put32(frame_t f, logic [31:0] v);
		frame_t g;
		g = put(f, v[7:0]);
		g = put(g, v[15:8]);
		g = put(g, v[23:16]);
		g = put(g, v[31:24]);
		return g;
	endfunction

	// 64-bit op, register-direct
	function automatic frame_t op_rr(frame_t f, logic [7:0] op, logic [3:0] rg, logic [3:0] rm);
		frame_t g;
		g = put(f, rexb(1'b1, rg, rm));
		g = put(g, op);
		g = put(g, modrm(2'd3, rg[2:0], rm[2:0]));
		return g;
	endfunction

	// 64-bit op with opcode extension in the reg field
	function automatic frame_t op_ext(frame_t f, logic [7:0] op, logic [2:0] ext, logic [3:0] rm);
		frame_t g;
		g = put(f, rexb(1'b1, 4'd0, rm));
		g = put(g, op);
		g = put(g, modrm(2'd3, ext, rm[2:0]));
		return g;
	endfunction

	// base plus offset addressing
	function automatic frame_t op_mem(frame_t f, logic [7:0] op, logic [3:0] rg,
			logic [3:0] base, logic [31:0] off);
		frame_t g;
		logic [1:0] md;
		g = put(f, rexb(1'b1, rg, base));
		g = put(g, op);
		if (off == '0 && base[2:0] != 3'd5)
			md = 2'd0;
		else if (fits8(off))
			md = 2'd1;
		else
			md = 2'd2;
		g = put(g, modrm(md, rg[2:0], base[2:0]));
		if (base[2:0] == 3'd4)
			g = put(g, 8'h24);
		if (md == 2'd1)
			g = put(g, off[7:0]);
		else if (md == 2'd2)
			g = put32(g, off);
		return g;
	endfunction

	// add/sub family with short or long immediate
	function automatic frame_t op_arith_imm(frame_t f, logic [2:0] ext, logic [3:0] dst,
			logic [31:0] imm);
		frame_t g;
		if (fits8(imm)) begin
			g = op_ext(f, 8'h83, ext, dst);
			g = put(g, imm[7:0]);
		end else begin
			g = op_ext(f, 8'h81, ext, dst);
			g = put32(g, imm);
		end
		return g;
	endfunction

	// push/pop register
	function automatic frame_t op_stack(frame_t f, logic [7:0] base, logic [3:0] r);
		frame_t g;
		g = f;
		if (r[3])
			g = put(g, 8'h41);
		g = put(g, base | {5'd0, r[2:0]});
		return g;
	endfunction

	// condition byte of setcc
	function automatic logic [7:0] cc_code(logic [5:0] c);
		logic [7:0] cc;
		case (c)
			CMD_SETE:  cc = 8'h94;
			CMD_SETNE: cc = 8'h95;
			CMD_SETL:  cc = 8'h9C;
			CMD_SETLE: cc = 8'h9E;
			CMD_SETG:  cc = 8'h9F;
			default:   cc = 8'h9D;
		endcase
		return cc;
	endfunction

	// whole encoding of one request
	function automatic frame_t encode(req_t r);
		frame_t      f;
		logic [3:0]  a;
		logic [3:0]  b;
		logic [31:0] i32;
		logic [31:0] al;
		f = '0;
		a = r.reg_a;
		b = r.reg_b;
		i32 = r.imm_value[31:0];
		// frame size rounded up to 16, wrapping in 32 bits
		al = {i32[31:4] + 28'(i32[3:0] != 4'd0), 4'd0};
		case (r.cmd)
			CMD_MOV_RR:    f = op_rr(f, 8'h89, b, a);
			CMD_MOV_RI64: begin
				f = put(f, rexb(1'b1, 4'd0, a));
				f = put(f, 8'hB8 | {5'd0, a[2:0]});
				f = put32(f, i32);
				f = put32(f, r.imm_value[63:32]);
			end
			CMD_MOV_LOAD:  f = op_mem(f, 8'h8B, a, b, i32);
			CMD_MOV_STORE: f = op_mem(f, 8'h89, b, a, i32);
			CMD_ADD_RR:    f = op_rr(f, 8'h01, b, a);
			CMD_ADD_RI:    f = op_arith_imm(f, 3'd0, a, i32);
			CMD_SUB_RR:    f = op_rr(f, 8'h29, b, a);
			CMD_SUB_RI:    f = op_arith_imm(f, 3'd5, a, i32);
			CMD_IMUL_RR, CMD_MOVZX: begin
				f = put(f, rexb(1'b1, a, b));
				f = put(f, 8'h0F);
				f = put(f, (r.cmd == CMD_MOVZX) ? 8'hB6 : 8'hAF);
				f = put(f, modrm(2'd3, a[2:0], b[2:0]));
			end
			CMD_CQO: begin
				f = put(f, 8'h48);
				f = put(f, 8'h99);
			end
			CMD_IDIV:      f = op_ext(f, 8'hF7, 3'd7, a);
			CMD_AND_RR:    f = op_rr(f, 8'h21, b, a);
			CMD_AND_RI8: begin
				f = op_ext(f, 8'h83, 3'd4, a);
				f = put(f, i32[7:0]);
			end
			CMD_OR_RR:     f = op_rr(f, 8'h09, b, a);
			CMD_XOR_RR:    f = op_rr(f, 8'h31, b, a);
			CMD_NOT:       f = op_ext(f, 8'hF7, 3'd2, a);
			CMD_NEG:       f = op_ext(f, 8'hF7, 3'd3, a);
			CMD_CMP_RR:    f = op_rr(f, 8'h39, b, a);
			CMD_CMP_RI: begin
				f = op_ext(f, 8'h81, 3'd7, a);
				f = put32(f, i32);
			end
			CMD_TEST_RR:   f = op_rr(f, 8'h85, b, a);
			CMD_SETE, CMD_SETNE, CMD_SETL, CMD_SETLE, CMD_SETG, CMD_SETGE: begin
				// byte registers spl..dil and r8b.. need a rex prefix
				if (a >= 4'd4)
					f = put(f, rexb(1'b0, 4'd0, a));
				f = put(f, 8'h0F);
				f = put(f, cc_code(r.cmd));
				f = put(f, modrm(2'd3, 3'd0, a[2:0]));
			end
			CMD_PUSH:      f = op_stack(f, 8'h50, a);
			CMD_POP:       f = op_stack(f, 8'h58, a);
			CMD_PUSH_IMM: begin
				f = put(f, 8'h68);
				f = put32(f, i32);
			end
			CMD_JMP: begin
				f = put(f, 8'hE9);
				f = put32(f, JUMP_PLACEHOLDER);
			end
			CMD_JE, CMD_JNE: begin
				f = put(f, 8'h0F);
				f = put(f, (r.cmd == CMD_JE) ? 8'h84 : 8'h85);
				f = put32(f, JUMP_PLACEHOLDER);
			end
			CMD_CALL: begin
				f = put(f, 8'hE8);
				f = put32(f, 32'd0);
			end
			CMD_RET:       f = put(f, 8'hC3);
			CMD_LEAVE:     f = put(f, 8'hC9);
			CMD_PROLOGUE: begin
				f = op_stack(f, 8'h50, REG_RBP);
				f = op_rr(f, 8'h89, REG_RSP, REG_RBP);
				if (al != '0 && !al[31])
					f = op_arith_imm(f, 3'd5, REG_RSP, al);
			end
			CMD_EPILOGUE: begin
				f = put(f, 8'hC9);
				f = put(f, 8'hC3);
			end
			CMD_SYSCALL: begin
				f = put(f, 8'h0F);
				f = put(f, 8'h05);
			end
			default:       f = '0;
		endcase
		return f;
	endfunction

	logic   valid_s1;
	frame_t frame_s1;
	logic   drain;
	logic   accept;
	logic   len_ok;

	// empty encodings are dropped, others wait for a queue slot
	assign drain  = valid_s1 && (!full || frame_s1.len == '0);
	assign push   = valid_s1 && !full && frame_s1.len != '0;
	assign busy   = valid_s1 && !drain;
	assign accept = start && !busy;
	assign frame  = frame_s1;

	// held frame length within the byte buffer
	assign len_ok = frame_s1.len != '0 && frame_s1.len <= LenW'(MaxBytes);

	// encode stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	// encode stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= encode(req);
		end
	end

	`ASSERT_CLK(a_busy_needs_held_frame, busy |-> valid_s1, "busy without a held frame")
	`ASSERT_CLK(a_push_has_bytes, push |-> len_ok, "bad frame length pushed")

endmodule

FILE: hw/rtl/x86e_fifo.sv
`include "assert_macros.svh"

module x86e_fifo import x86e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t wr_frame,
	input  logic   pop,
	output frame_t head,
	output logic   full,
	output logic   empty
);

	localparam int PtrW = $clog2(FifoDepth);
	localparam int CntW = $clog2(FifoDepth + 1);

	frame_t [FifoDepth-1:0] slot_q;
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = count_q == CntW'(FifoDepth);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_frame;
		end
	end

	`ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
	`ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule

FILE: hw/rtl/x86e_back.sv
`include "assert_macros.svh"

module x86e_back import x86e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  frame_t head,
	input  logic   empty,
	output logic   pop,
	output logic   strobe,
	output res_t   res
);

	logic [LenW-1:0] idx_q;
	logic            strobe_q;
	res_t            res_q;
	logic            emit;
	logic            last;

	// one byte of the head instruction per cycle
	assign emit   = !empty;
	assign last   = idx_q == (head.len - 1'b1);
	assign pop    = emit && last;
	assign strobe = strobe_q;
	assign res    = res_q;

	// byte index and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (emit)
				idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_byte  <= head.bytes[idx_q];
			res_q.last_byte <= last;
		end
	end

	`ASSERT_CLK(a_pop_marks_last, pop |=> (strobe && res.last_byte), "pop without last byte")
	`ASSERT_CLK(a_idx_in_frame, emit |-> (idx_q < head.len), "byte index past frame end")

endmodule

FILE: hw/rtl/x86_64_instruction_encoder.sv
// x86_64 instruction encoder. A request (start high while busy is low) carries one
// instruction form plus two registers and a 64-bit immediate; the block returns its
// machine code one byte per cycle on res, each byte marked by a one-cycle strobe, with
// res.last_byte set on the final byte. The receiver cannot stall: every strobed byte
// must be taken in that cycle. An encoding is 1 to 11 bytes long (typically 3 or 4);
// new requests are accepted while earlier bytes are still being sent, but the sustained
// rate is set by the byte serializer. The first byte passes the encode register, the
// instruction queue and the result register. Unknown forms produce no bytes. busy
// rises when the encode register and the two-entry instruction queue are all occupied.
module x86_64_instruction_encoder import x86e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output res_t res
);

	frame_t enc_frame;
	frame_t head;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	// encode front end
	x86e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.full   (full),
		.push   (push),
		.frame  (enc_frame)
	);

	// instruction queue
	x86e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (enc_frame),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	// byte serializer
	x86e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.strobe (strobe),
		.res    (res)
	);

endmodule

FILE: tb/sv/x86_64_instruction_encoder_tb.sv
`timescale 1ns / 100ps

module x86_64_instruction_encoder_tb;
	import x86e_pkg::*;

	// first unknown form and the top of the form range
	localparam logic [5:0] CMD_COUNT = 6'd39;
	localparam logic [5:0] CMD_TOP   = 6'd63;

	// register numbers that get special encodings
	localparam logic [3:0] REG_RAX = 4'd0;
	localparam logic [3:0] REG_RBX = 4'd3;
	localparam logic [3:0] REG_R8  = 4'd8;
	localparam logic [3:0] REG_R12 = 4'd12;
	localparam logic [3:0] REG_R13 = 4'd13;
	localparam logic [3:0] REG_R15 = 4'd15;

	// opcode extensions in the modrm reg field
	localparam logic [2:0] EXT_ADD  = 3'd0;
	localparam logic [2:0] EXT_NOT  = 3'd2;
	localparam logic [2:0] EXT_NEG  = 3'd3;
	localparam logic [2:0] EXT_AND  = 3'd4;
	localparam logic [2:0] EXT_SUB  = 3'd5;
	localparam logic [2:0] EXT_CMP  = 3'd7;
	localparam logic [2:0] EXT_IDIV = 3'd7;

	localparam logic [7:0] SETCC_OP [6] = '{8'h94, 8'h95, 8'h9C, 8'h9E, 8'h9F, 8'h9D};
	localparam logic [31:0] BRANCH_DISP = 32'hDEADBEEF;

	// 32-bit immediates around the imm8/imm32 and frame alignment boundaries
	localparam logic [31:0] IMM_EDGES [10] = '{
		32'h0000007F, 32'h00000080, 32'hFFFFFF80, 32'hFFFFFF7F, 32'h7FFFFFFF,
		32'h80000000, 32'h7FFFFFF0, 32'h7FFFFFF1, 32'hFFFFFFFF, 32'h00000010};

	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 290;

	// encoding predictor and byte-stream checker
	class encode_scoreboard;
		res_t pending_bytes[$];
		logic [7:0] enc[$];
		int failures;

		function new();
			failures = 0;
		endfunction

		function void put8(logic [31:0] v);
			enc.push_back(v[7:0]);
		endfunction

		function void put32(logic [31:0] v);
			put8(v);
			put8(v >> 8);
			put8(v >> 16);
			put8(v >> 24);
		endfunction

		function logic [7:0] rex(logic w, logic [3:0] r, logic [3:0] b);
			return {4'h4, w, r[3], 1'b0, b[3]};
		endfunction

		function logic [7:0] modrm(logic [1:0] md, logic [3:0] r, logic [3:0] rm);
			return {md, r[2:0], rm[2:0]};
		endfunction

		function bit fits8(logic [31:0] v);
			logic [31:0] t;
			t = v + 32'd128;
			return t < 32'd256;
		endfunction

		function void reg_reg(logic [7:0] op, logic [3:0] r, logic [3:0] rm);
			put8(rex(1'b1, r, rm));
			put8(op);
			put8(modrm(2'd3, r, rm));
		endfunction

		function void reg_ext(logic [7:0] op, logic [2:0] ext, logic [3:0] rm);
			put8(rex(1'b1, REG_RAX, rm));
			put8(op);
			put8(modrm(2'd3, {1'b0, ext}, rm));
		endfunction

		// memory operand: base+offset with disp0/disp8/disp32 and rsp-style sib
		function void mem_op(logic [7:0] op, logic [3:0] r, logic [3:0] base,
				logic [31:0] off);
			logic [1:0] md;
			put8(rex(1'b1, r, base));
			put8(op);
			if (off == 0 && base[2:0] != REG_RBP[2:0]) md = 2'd0;
			else if (fits8(off)) md = 2'd1;
			else md = 2'd2;
			put8(modrm(md, r, base));
			if (base[2:0] == REG_RSP[2:0]) put8(32'h24);
			if (md == 2'd1) put8(off);
			else if (md == 2'd2) put32(off);
		endfunction

		function void arith_imm(logic [2:0] ext, logic [3:0] dst, logic [31:0] imm);
			if (fits8(imm)) begin
				reg_ext(8'h83, ext, dst);
				put8(imm);
			end else begin
				reg_ext(8'h81, ext, dst);
				put32(imm);
			end
		endfunction

		function void push_pop(logic [7:0] base, logic [3:0] r);
			if (r[3]) put8(32'h41);
			put8({base[7:3], r[2:0]});
		endfunction

		function void branch(logic [7:0] op1, logic [7:0] op2);
			if (op1 != 0) put8(op1);
			put8(op2);
			put32(BRANCH_DISP);
		endfunction

		// queue the byte stream the accepted request must produce
		function void note_request(req_t r);
			logic [3:0] a;
			logic [3:0] b;
			logic [31:0] i32;
			logic [31:0] aligned;
			a = r.reg_a;
			b = r.reg_b;
			i32 = r.imm_value[31:0];
			enc.delete();
			case (r.cmd)
				CMD_MOV_RR: reg_reg(8'h89, b, a);
				CMD_MOV_RI64: begin
					put8(rex(1'b1, REG_RAX, a));
					put8({5'b10111, a[2:0]});
					put32(i32);
					put32(r.imm_value[63:32]);
				end
				CMD_MOV_LOAD: mem_op(8'h8B, a, b, i32);
				CMD_MOV_STORE: mem_op(8'h89, b, a, i32);
				CMD_ADD_RR: reg_reg(8'h01, b, a);
				CMD_ADD_RI: arith_imm(EXT_ADD, a, i32);
				CMD_SUB_RR: reg_reg(8'h29, b, a);
				CMD_SUB_RI: arith_imm(EXT_SUB, a, i32);
				CMD_IMUL_RR, CMD_MOVZX: begin
					put8(rex(1'b1, a, b));
					put8(32'h0F);
					put8((r.cmd == CMD_IMUL_RR) ? 32'hAF : 32'hB6);
					put8(modrm(2'd3, a, b));
				end
				CMD_CQO: begin
					put8(32'h48);
					put8(32'h99);
				end
				CMD_IDIV: reg_ext(8'hF7, EXT_IDIV, a);
				CMD_AND_RR: reg_reg(8'h21, b, a);
				CMD_AND_RI8: begin
					reg_ext(8'h83, EXT_AND, a);
					put8(i32);
				end
				CMD_OR_RR: reg_reg(8'h09, b, a);
				CMD_XOR_RR: reg_reg(8'h31, b, a);
				CMD_NOT: reg_ext(8'hF7, EXT_NOT, a);
				CMD_NEG: reg_ext(8'hF7, EXT_NEG, a);
				CMD_CMP_RR: reg_reg(8'h39, b, a);
				CMD_CMP_RI: begin
					reg_ext(8'h81, EXT_CMP, a);
					put32(i32);
				end
				CMD_TEST_RR: reg_reg(8'h85, b, a);
				CMD_SETE, CMD_SETNE, CMD_SETL, CMD_SETLE, CMD_SETG, CMD_SETGE: begin
					// spl..dil and r8b.. need a rex prefix
					if (a >= REG_RSP) put8(rex(1'b0, REG_RAX, a));
					put8(32'h0F);
					put8(SETCC_OP[r.cmd - CMD_SETE]);
					put8(modrm(2'd3, REG_RAX, a));
				end
				CMD_PUSH: push_pop(8'h50, a);
				CMD_POP: push_pop(8'h58, a);
				CMD_PUSH_IMM: begin
					put8(32'h68);
					put32(i32);
				end
				CMD_JMP: branch(8'h00, 8'hE9);
				CMD_JE: branch(8'h0F, 8'h84);
				CMD_JNE: branch(8'h0F, 8'h85);
				CMD_CALL: begin
					put8(32'hE8);
					put32(32'h0);
				end
				CMD_RET: put8(32'hC3);
				CMD_LEAVE: put8(32'hC9);
				CMD_PROLOGUE: begin
					push_pop(8'h50, REG_RBP);
					reg_reg(8'h89, REG_RSP, REG_RBP);
					// frame size rounded up to 16, dropped when zero or negative
					aligned = (i32 + 32'd15) & 32'hFFFFFFF0;
					if (aligned != 0 && !aligned[31]) arith_imm(EXT_SUB, REG_RSP, aligned);
				end
				CMD_EPILOGUE: begin
					put8(32'hC9);
					put8(32'hC3);
				end
				CMD_SYSCALL: begin
					put8(32'h0F);
					put8(32'h05);
				end
				default: ;
			endcase
			foreach (enc[k])
				pending_bytes.push_back('{out_byte: enc[k], last_byte: (k == enc.size() - 1)});
		endfunction

		// compare one strobed byte against the oldest expectation
		function void check_byte(res_t got);
			res_t exp_b;
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte %02h (last %0b) with no transaction pending",
					got.out_byte, got.last_byte);
				failures++;
				return;
			end
			exp_b = pending_bytes.pop_front();
			if (got.out_byte !== exp_b.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", exp_b.out_byte, got.out_byte);
				failures++;
			end
			if (got.last_byte !== exp_b.last_byte) begin
				$error("last_byte: expected %0b, actual %0b", exp_b.last_byte, got.last_byte);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic strobe;
	res_t res;
	int cycle_count;
	encode_scoreboard board;

	x86_64_instruction_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.res    (res)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// byte monitor
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) board.check_byte(res);
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// immediates spread over zero, small, boundary and full-width values
	function automatic logic signed [63:0] random_imm();
		logic [31:0] lo;
		lo = $urandom;
		case ($urandom_range(5))
			0: return 64'sd0;
			1: begin
				lo = $urandom_range(300) - 150;
				return {{32{lo[31]}}, lo};
			end
			2: return {$urandom, lo};
			3: return {{32{lo[31]}}, lo};
			4: return {$urandom, IMM_EDGES[$urandom_range(9)]};
			default: return {$urandom, 24'h0, lo[7:0]};
		endcase
	endfunction

	// present one request, holding it until the encoder takes it
	task automatic send_request(input req_t r, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_request(r);
	endtask

	task automatic issue(input logic [5:0] c, input logic [3:0] a, input logic [3:0] b,
			input logic signed [63:0] imm);
		req_t r;
		r.cmd = c;
		r.reg_a = a;
		r.reg_b = b;
		r.imm_value = imm;
		send_request(r, 0);
	endtask

	// stop sending and wait until every expected byte has come out
	task automatic drain_bytes();
		int n;
		n = 0;
		start <= 1'b0;
		while (board.pending_bytes.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic random_phase(input int count, input int idle_pct);
		req_t r;
		int valid;
		valid = 0;
		while (valid < count) begin
			if ($urandom_range(99) < 5) r.cmd = 6'($urandom_range(CMD_TOP, CMD_COUNT));
			else r.cmd = 6'($urandom_range(CMD_COUNT - 1));
			r.reg_a = 4'($urandom_range(15));
			r.reg_b = 4'($urandom_range(15));
			r.imm_value = random_imm();
			send_request(r, idle_pct);
			if (r.cmd < CMD_COUNT) valid++;
		end
	endtask

	// stimulus
	initial begin
		board = new();
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown forms produce nothing
		issue(CMD_COUNT, REG_RAX, REG_RAX, 64'sd0);
		issue(CMD_TOP, REG_R15, REG_R15, -64'sd1);
		// rbp/r13 base never uses the no-displacement form
		issue(CMD_MOV_LOAD, REG_RAX, REG_RBP, 64'sd0);
		issue(CMD_MOV_STORE, REG_R13, REG_R15, 64'sd0);
		// rsp/r12 base takes a sib byte
		issue(CMD_MOV_STORE, REG_RSP, REG_RBX, 64'sd0);
		issue(CMD_MOV_LOAD, REG_R15, REG_R12, 64'sh1000);
		// disp8 and imm8 limits
		issue(CMD_MOV_LOAD, REG_R8, REG_RBX, 64'sd127);
		issue(CMD_MOV_LOAD, REG_R8, REG_RBX, -64'sd129);
		issue(CMD_ADD_RI, REG_R15, REG_RAX, 64'sd128);
		issue(CMD_SUB_RI, REG_RAX, REG_RAX, -64'sd128);
		issue(CMD_ADD_RI, REG_RBX, REG_RAX, 64'shFFFF_FFFF_8000_0000);
		issue(CMD_CMP_RI, REG_R12, REG_RAX, 64'sd5);
		// byte registers with and without a rex prefix
		issue(CMD_SETE, REG_RBX, REG_RAX, 64'sd0);
		issue(CMD_SETNE, REG_RSP, REG_RAX, 64'sd0);
		issue(CMD_SETGE, REG_R15, REG_RAX, 64'sd0);
		issue(CMD_PUSH, REG_R15, REG_RAX, 64'sd0);
		// frame sizes: none, imm8, imm32, overflow to negative, wrap to zero, largest imm32
		issue(CMD_PROLOGUE, REG_RAX, REG_RAX, 64'sd0);
		issue(CMD_PROLOGUE, REG_RAX, REG_RAX, 64'sd1);
		issue(CMD_PROLOGUE, REG_RAX, REG_RAX, 64'sd200);
		issue(CMD_PROLOGUE, REG_RAX, REG_RAX, 64'sh7FFF_FFF1);
		issue(CMD_PROLOGUE, REG_RAX, REG_RAX, -64'sd1);
		issue(CMD_PROLOGUE, REG_R15, REG_R15, 64'sh7FFF_FFF0);
		// imm64 extremes
		issue(CMD_MOV_RI64, REG_R15, REG_RAX, 64'sh8000_0000_0000_0000);
		issue(CMD_MOV_RI64, REG_RAX, REG_R15, -64'sd1);
		// every form once
		for (int c = 0; c < CMD_COUNT; c++)
			issue(c[5:0], 4'($urandom_range(15)), 4'($urandom_range(15)), random_imm());

		// random phases with a full drain before each one
		drain_bytes();
		random_phase(RANDOM_ITEMS / 3, 0);
		drain_bytes();
		random_phase(RANDOM_ITEMS / 3, 67);
		drain_bytes();
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 8);

		drain_bytes();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", board.pending_bytes.size());
			board.failures++;
		end
		if (board.failures == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
